/* rtl/set_median_select_macros.svh */
// Assertion macros used by the median selection RTL.
`ifndef SET_MEDIAN_SELECT_MACROS_SVH
`define SET_MEDIAN_SELECT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Antecedent implies consequent in the same cycle.
`define SMSEL_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("median select assertion failed");
// Antecedent implies consequent in the next cycle.
`define SMSEL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("median select assertion failed");
`else
`define SMSEL_ASSERT_SAME(label, ante, cons)
`define SMSEL_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* rtl/smsel_pkg.sv */
// Package with constants and types of the median selection block.
`timescale 1ns / 1ps
`default_nettype none

package smsel_pkg;

    localparam int MAX_ITEMS  = 256;
    localparam int VALUE_BITS = 32;
    localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
    localparam int IDX_W      = $clog2(MAX_ITEMS);

    typedef logic signed [VALUE_BITS-1:0] value_t;
    typedef logic [CNT_W-1:0]             count_t;
    typedef logic [IDX_W-1:0]             index_t;

    typedef struct packed {
        logic   ins;
        logic   shift;
        value_t value;
    } smsel_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_SUM
    } smsel_state_t;

endpackage

`default_nettype wire

/* rtl/smsel_cell.sv */
// One cell of the sorted insertion chain.
`timescale 1ns / 1ps
`default_nettype none

module smsel_cell
    import smsel_pkg::*;
(
    input  wire logic       clk,
    input  wire smsel_cmd_t cmd,
    input  wire logic       occupied,
    input  wire logic       left_gt,
    input  wire value_t     left_value,
    input  wire value_t     right_value,
    output logic            gt,
    output value_t          value
);

    value_t value_reg;
    value_t value_next;

    // An empty cell counts as greater than any value, so the new value lands
    // in the first empty cell when nothing stored exceeds it.
    assign gt    = !occupied || (value_reg > cmd.value);
    assign value = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (cmd.shift)
        begin
            value_next = right_value;
        end
        else if (cmd.ins && gt)
        begin
            value_next = left_gt ? left_value : cmd.value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

/* rtl/set_median_select.sv */
// Top level of the median selection block: cell chain and control.
//
//  Channel  | Handshake                      | Payload
//  ---------+--------------------------------+------------------------------------------
//  sample   | sample_valid / sample_ready    | sample_value, last_item
//  result   | result_valid / result_ready    | median_value, items_used, capacity_exceeded
//
// The chain inserts each item without the last mark in sorted place while not full.
// After a last item holding n stored values, the chain shifts down by (n-1)/2 places,
// then forms the median once the output register is free; the input stalls until then.
// The result waits in an output register, so the next set may start while it is unread;
// the following median then waits until that result has been taken.
// Reset clears the fill count and flags; cell contents are left as they are.
`timescale 1ns / 1ps
`default_nettype none

`include "set_median_select_macros.svh"

module set_median_select
    import smsel_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            sample_valid,
    output logic                 sample_ready,
    input  wire value_t          sample_value,
    input  wire logic            last_item,
    output logic                 result_valid,
    input  wire logic            result_ready,
    output value_t               median_value,
    output count_t               items_used,
    output logic                 capacity_exceeded
);

    smsel_state_t state_reg, state_next;
    count_t       fill_reg, fill_next;
    logic         ovf_reg, ovf_next;
    index_t       cnt_reg, cnt_next;
    logic         result_valid_reg, result_valid_next;
    value_t       median_reg;
    count_t       items_reg;
    logic         exceeded_reg;

    smsel_cmd_t   cmd;
    logic         load_out;
    logic         full;
    count_t       n_new;
    count_t       n_less;
    count_t       lo_full;

    value_t       cell_value [MAX_ITEMS];
    logic         cell_gt    [MAX_ITEMS];

    logic signed [VALUE_BITS:0] pair_sum;
    logic signed [VALUE_BITS:0] pair_adj;
    value_t                     median_calc;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ITEMS; gi++)
        begin : g_cell
            logic   occ;
            logic   l_gt;
            value_t l_val;
            value_t r_val;

            assign occ = (CNT_W'(gi) < fill_reg);

            if (gi == 0)
            begin : g_first
                assign l_gt  = 1'b0;
                assign l_val = cell_value[gi];
            end
            else
            begin : g_mid
                assign l_gt  = cell_gt[gi-1];
                assign l_val = cell_value[gi-1];
            end

            if (gi == MAX_ITEMS - 1)
            begin : g_last
                assign r_val = cell_value[gi];
            end
            else
            begin : g_inner
                assign r_val = cell_value[gi+1];
            end

            smsel_cell u_cell (
                .clk         (clk),
                .cmd         (cmd),
                .occupied    (occ),
                .left_gt     (l_gt),
                .left_value  (l_val),
                .right_value (r_val),
                .gt          (cell_gt[gi]),
                .value       (cell_value[gi])
            );
        end
    endgenerate

    assign full    = (fill_reg == CNT_W'(MAX_ITEMS));
    assign n_new   = full ? fill_reg : fill_reg + 1'b1;
    assign n_less  = n_new - 1'b1;
    assign lo_full = n_less >> 1;

    // Sum of the two middle values one bit wider, halved toward zero.
    assign pair_sum    = {cell_value[0][VALUE_BITS-1], cell_value[0]}
                       + {cell_value[1][VALUE_BITS-1], cell_value[1]};
    assign pair_adj    = pair_sum + {{VALUE_BITS{1'b0}}, pair_sum[VALUE_BITS]};
    assign median_calc = fill_reg[0] ? cell_value[0] : pair_adj[VALUE_BITS:1];

    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        ovf_next     = ovf_reg;
        cnt_next     = cnt_reg;
        cmd.ins      = 1'b0;
        cmd.shift    = 1'b0;
        cmd.value    = sample_value;
        load_out     = 1'b0;
        sample_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                sample_ready = 1'b1;
                if (sample_valid)
                begin
                    cmd.ins   = !full;
                    fill_next = n_new;
                    ovf_next  = ovf_reg | full;
                    if (last_item)
                    begin
                        cnt_next   = lo_full[IDX_W-1:0];
                        state_next = (lo_full != '0) ? ST_SHIFT : ST_SUM;
                    end
                end
            end
            ST_SHIFT:
            begin
                cmd.shift = 1'b1;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == index_t'(1))
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    load_out   = 1'b1;
                    fill_next  = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign result_valid_next = load_out | (result_valid_reg & !result_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            fill_reg         <= '0;
            ovf_reg          <= 1'b0;
            cnt_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            fill_reg         <= fill_next;
            ovf_reg          <= ovf_next;
            cnt_reg          <= cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            median_reg   <= median_calc;
            items_reg    <= fill_reg;
            exceeded_reg <= ovf_reg;
        end
    end

    assign result_valid      = result_valid_reg;
    assign median_value      = median_reg;
    assign items_used        = items_reg;
    assign capacity_exceeded = exceeded_reg;

    `SMSEL_ASSERT_SAME(a_fill_range, 1'b1, fill_reg <= CNT_W'(MAX_ITEMS))
    `SMSEL_ASSERT_SAME(a_shift_count, state_reg == ST_SHIFT, cnt_reg != '0)
    `SMSEL_ASSERT_NEXT(a_clear_after_result, load_out, fill_reg == '0 && !ovf_reg)
    `SMSEL_ASSERT_NEXT(a_fill_step, sample_valid && sample_ready && !last_item && !full,
        fill_reg == $past(fill_reg) + 1'b1)
    `SMSEL_ASSERT_SAME(a_load_only_free, load_out, !result_valid_reg || result_ready)

endmodule

`default_nettype wire

/* verif/median_compare.sv */
// Median comparison: watches both channels of the block, predicts each median and compares it.
`timescale 1ns / 1ps

module median_compare
    import smsel_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   sample_valid,
    input  logic   sample_ready,
    input  value_t sample_value,
    input  logic   last_item,
    input  logic   result_valid,
    input  logic   result_ready,
    input  value_t median_value,
    input  count_t items_used,
    input  logic   capacity_exceeded,
    output int     mismatches,
    output int     medians_due,
    output int     medians_checked
);

    typedef struct {
        value_t median;
        count_t used;
        logic   dropped;
    } median_t;

    value_t  stored_values[$];
    logic    store_overflow = 1'b0;
    median_t pending_medians[$];
    int      fault_count = 0;
    int      checked_count = 0;

    function automatic value_t median_of_stored();
        int     n;
        longint pair_sum;
        n = stored_values.size();
        if (n % 2 == 1)
            return stored_values[n / 2];
        // The pair is summed in 64 bits, so the sum never wraps.
        pair_sum = longint'(stored_values[n / 2]) + longint'(stored_values[n / 2 - 1]);
        return value_t'(pair_sum / 2);
    endfunction

    function automatic void take_sample(value_t v, logic last);
        int      pos;
        median_t due;
        if (stored_values.size() < MAX_ITEMS)
        begin
            pos = stored_values.size();
            while (pos > 0 && stored_values[pos - 1] > v)
                pos--;
            stored_values.insert(pos, v);
        end
        else
            store_overflow = 1'b1;
        if (last)
        begin
            due.median  = median_of_stored();
            due.used    = count_t'(stored_values.size());
            due.dropped = store_overflow;
            pending_medians.insert(pending_medians.size(), due);
            stored_values.delete();
            store_overflow = 1'b0;
        end
    endfunction

    function automatic void report_fault(string what);
        fault_count++;
        if (fault_count <= 10)
            $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    function automatic void check_result();
        median_t due;
        if (pending_medians.size() == 0)
        begin
            report_fault($sformatf("unexpected result median=%0d used=%0d dropped=%0b",
                median_value, items_used, capacity_exceeded));
            return;
        end
        due = pending_medians.pop_front();
        checked_count++;
        if (median_value !== due.median || items_used !== due.used ||
            capacity_exceeded !== due.dropped)
            report_fault($sformatf("expected median=%0d used=%0d dropped=%0b, got %0d %0d %0b",
                due.median, due.used, due.dropped, median_value, items_used,
                capacity_exceeded));
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_values.delete();
            pending_medians.delete();
            store_overflow = 1'b0;
            mismatches      <= 0;
            medians_due     <= 0;
            medians_checked <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
                check_result();
            if (sample_valid && sample_ready)
                take_sample(sample_value, last_item);
            mismatches      <= fault_count;
            medians_due     <= pending_medians.size();
            medians_checked <= checked_count;
        end
    end

endmodule

/* verif/testbench.sv */
// Top of the median selection testbench: clock, reset, stimulus and the final verdict.
`timescale 1ns / 1ps

module testbench;
    import smsel_pkg::*;

    localparam int     CYCLE_LIMIT = 200000;
    localparam int     HOLD_CYCLES = 300;
    localparam int     TAIL_CYCLES = MAX_ITEMS / 2 + 16;
    localparam int     RANDOM_ITEMS = 80;
    localparam value_t VALUE_MAX = {1'b0, {(VALUE_BITS - 1){1'b1}}};
    localparam value_t VALUE_MIN = {1'b1, {(VALUE_BITS - 1){1'b0}}};

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   sample_valid = 1'b0;
    logic   last_item = 1'b0;
    logic   result_ready = 1'b0;
    value_t sample_value = '0;
    logic   sample_ready;
    logic   result_valid;
    value_t median_value;
    count_t items_used;
    logic   capacity_exceeded;

    int   mismatches;
    int   medians_due;
    int   medians_checked;
    int   cycle_count = 0;
    int   items_sent = 0;
    int   sets_sent = 0;
    int   holds_asked = 0;
    int   holds_done = 0;
    logic quiet = 1'b0;

    always #2 clk = ~clk;

    set_median_select i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .sample_valid      (sample_valid),
        .sample_ready      (sample_ready),
        .sample_value      (sample_value),
        .last_item         (last_item),
        .result_valid      (result_valid),
        .result_ready      (result_ready),
        .median_value      (median_value),
        .items_used        (items_used),
        .capacity_exceeded (capacity_exceeded)
    );

    median_compare i_median_compare (
        .clk               (clk),
        .rst_n             (rst_n),
        .sample_valid      (sample_valid),
        .sample_ready      (sample_ready),
        .sample_value      (sample_value),
        .last_item         (last_item),
        .result_valid      (result_valid),
        .result_ready      (result_ready),
        .median_value      (median_value),
        .items_used        (items_used),
        .capacity_exceeded (capacity_exceeded),
        .mismatches        (mismatches),
        .medians_due       (medians_due),
        .medians_checked   (medians_checked)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Run stopped after %0d cycles without completing.", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (holds_done != holds_asked)
            begin
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                result_ready <= 1'b1;
                holds_done++;
            end
            else if (!quiet && $urandom_range(0, 6) == 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                result_ready <= 1'b1;
            end
            else
                result_ready <= 1'b1;
        end
    end

    function automatic value_t pick_value(int mode);
        case (mode)
            0:       return value_t'($urandom);
            1:       return value_t'(int'($urandom_range(0, 16)) - 8);
            2:
            begin
                if ($urandom_range(0, 1) == 1)
                    return VALUE_MAX - value_t'($urandom_range(0, 3));
                return VALUE_MIN + value_t'($urandom_range(0, 3));
            end
            default: return pick_value($urandom_range(0, 2));
        endcase
    endfunction

    task automatic send_item(value_t v, logic last);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_value <= v;
        last_item    <= last;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        items_sent++;
        if (last)
            sets_sent++;
    endtask

    task automatic send_set(input value_t vals[$]);
        foreach (vals[i])
            send_item(vals[i], i == vals.size() - 1);
    endtask

    task automatic send_random_set(int count);
        value_t vals[$];
        int     mode;
        mode = $urandom_range(0, 3);
        repeat (count)
            vals.insert(vals.size(), pick_value(mode));
        send_set(vals);
    endtask

    task automatic wait_for_medians();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (medians_due != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int random_start;
        int set_size;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        send_set('{VALUE_MAX});
        send_set('{VALUE_MIN});
        send_set('{VALUE_MAX, VALUE_MAX});
        send_set('{VALUE_MIN, VALUE_MIN});
        send_set('{VALUE_MIN, VALUE_MAX});
        send_set('{value_t'(-3), value_t'(0)});
        send_set('{value_t'(-1), value_t'(0)});
        send_set('{value_t'(5), value_t'(5), value_t'(5)});
        send_set('{value_t'(7), value_t'(-2), value_t'(7), value_t'(3)});
        send_set('{value_t'(3), value_t'(2), value_t'(1)});
        wait_for_medians();

        holds_asked++;
        repeat (8)
            send_random_set($urandom_range(2, 5));
        wait_for_medians();

        send_random_set(MAX_ITEMS);
        send_random_set(MAX_ITEMS + 3);

        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            if (items_sent - random_start >= RANDOM_ITEMS * 3 / 4)
                quiet = 1'b1;
            if ($urandom_range(0, 9) == 0)
                set_size = $urandom_range(10, 40);
            else
                set_size = $urandom_range(1, 6);
            send_random_set(set_size);
        end

        wait_for_medians();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d sample items in %0d sets with %0d medians compared,",
            items_sent, sets_sent, medians_checked);
        $display("including extreme and equal values, even-count averages and a full store.");
        if (mismatches == 0 && medians_due == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/smsel_pkg.sv
rtl/smsel_cell.sv
rtl/set_median_select.sv
verif/median_compare.sv
verif/testbench.sv
